// ----- hw/rtl/b64e_pkg.sv -----
// shared types, constants and the sextet-to-character map of the base64 encoder
`default_nettype none

package b64e_pkg;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] PAD_CHAR     = 8'd61;
    localparam logic [5:0] GPL_RESET    = 6'd16;
    localparam int         MAX_CHARS    = 5;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [7:0] char_t;

    // characters made by one input item, handed to the serializer
    typedef struct packed {
        logic                        load;
        logic [2:0]                  count;
        logic [MAX_CHARS-1:0][7:0]   chars;
    } burst_t;

    function automatic char_t sextet_char(input logic [5:0] v);
        char_t c;
        case (v) inside
            [6'd0:6'd25]:  c = 8'({2'b00, v}) + 8'd65;
            [6'd26:6'd51]: c = 8'({2'b00, v}) + 8'd71;
            [6'd52:6'd61]: c = 8'({2'b00, v}) - 8'd4;
            6'd62:         c = 8'd43;
            default:       c = 8'd47;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/b64e_in_if.sv -----
// input channel: raw bytes and end-of-message items
`default_nettype none

interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/b64e_out_if.sv -----
// output channel: encoded characters
`default_nettype none

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/b64e_encode.sv -----
// input register, group state and character generation for one item
`default_nettype none

module b64e_encode
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    b64e_in_if.sink         in_chan,
    input  wire logic [5:0] groups_per_line,
    input  wire logic       take,
    output burst_t          burst
);

    logic       in_valid_reg;
    logic       kind_reg;
    logic [7:0] data_reg;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic [5:0] gol_reg, gol_next;
    logic       any_reg, any_next;

    logic       move;
    logic [5:0] gol_inc;
    logic       final_nl;

    assign move          = in_valid_reg && take;
    assign in_chan.ready = !in_valid_reg || take;
    assign gol_inc       = gol_reg + 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_valid_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            kind_reg <= in_chan.kind;
            data_reg <= in_chan.data_byte;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        gol_next    = gol_reg;
        any_next    = any_reg;
        final_nl    = any_reg || (phase_reg != 2'd0);
        burst.load  = move;
        burst.count = 3'd0;
        burst.chars = '0;

        if (kind_reg == KIND_DATA)
        begin
            case (phase_reg)
                2'd0:
                begin
                    b0_next    = data_reg;
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    b1_next    = data_reg;
                    phase_next = 2'd2;
                end
                default:
                begin
                    burst.chars[0] = sextet_char(b0_reg[7:2]);
                    burst.chars[1] = sextet_char({b0_reg[1:0], b1_reg[7:4]});
                    burst.chars[2] = sextet_char({b1_reg[3:0], data_reg[7:6]});
                    burst.chars[3] = sextet_char(data_reg[5:0]);
                    phase_next     = 2'd0;
                    any_next       = 1'b1;
                    if (gol_inc == groups_per_line)
                    begin
                        burst.chars[4] = NEWLINE_CHAR;
                        burst.count    = 3'd5;
                        gol_next       = 6'd0;
                    end
                    else
                    begin
                        burst.count = 3'd4;
                        gol_next    = gol_inc;
                    end
                end
            endcase
        end
        else
        begin
            if (phase_reg != 2'd0)
            begin
                burst.chars[0] = sextet_char(b0_reg[7:2]);
                if (phase_reg == 2'd1)
                begin
                    burst.chars[1] = sextet_char({b0_reg[1:0], 4'd0});
                    burst.chars[2] = PAD_CHAR;
                end
                else
                begin
                    burst.chars[1] = sextet_char({b0_reg[1:0], b1_reg[7:4]});
                    burst.chars[2] = sextet_char({b1_reg[3:0], 2'd0});
                end
                burst.chars[3] = PAD_CHAR;
                burst.chars[4] = NEWLINE_CHAR;
                burst.count    = 3'd5;
            end
            else if (final_nl)
            begin
                burst.chars[0] = NEWLINE_CHAR;
                burst.count    = 3'd1;
            end
            // message done, back to the idle group state
            phase_next = 2'd0;
            b0_next    = 8'd0;
            b1_next    = 8'd0;
            gol_next   = 6'd0;
            any_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            b0_reg    <= 8'd0;
            b1_reg    <= 8'd0;
            gol_reg   <= 6'd0;
            any_reg   <= 1'b0;
        end
        else if (move)
        begin
            phase_reg <= phase_next;
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
            gol_reg   <= gol_next;
            any_reg   <= any_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/b64e_serialize.sv -----
// holds one item's characters and sends them out one per cycle while the output is not stalled
`default_nettype none

module b64e_serialize
    import b64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  burst_t    burst,
    output logic      take,
    b64e_out_if.source out_chan
);

    logic [2:0]                rem_reg;
    logic [MAX_CHARS-1:0][7:0] chars_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_char_reg;
    logic                      out_last_reg;
    logic                      out_load;

    assign out_load = (rem_reg != 3'd0) && (!out_valid_reg || out_chan.ready);
    // free once the held burst is gone or its final character moves out now
    assign take     = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && out_load);

    assign out_chan.valid    = out_valid_reg;
    assign out_chan.out_char = out_char_reg;
    assign out_chan.last     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
        end
        else if (burst.load)
        begin
            rem_reg <= burst.count;
        end
        else if (out_load)
        begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst.load)
        begin
            chars_reg <= burst.chars;
        end
        else if (out_load)
        begin
            chars_reg <= {8'd0, chars_reg[MAX_CHARS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= chars_reg[0];
            out_last_reg <= (rem_reg == 3'd1);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/base64_stream_encoder.sv -----
// base64 stream encoder top level: config register, encoder and serializer
//
//  channel   dir  payload                 transfer when
//  in_chan   in   kind, data_byte         valid && ready
//  out_chan  out  out_char, last          valid && ready
//  cfg       in   cfg_data (6 bits)       cfg_we
//
// an item is held in the input register after its transfer and is encoded once
// the serializer takes it; its characters then leave one per cycle while the
// output is not stalled; a full group gives 4 characters, or 5 with a newline,
// and its first character passes the input, character and output registers
// a stalled output keeps its character; one further item is still taken into
// the input register while the characters of the item before it are waiting
// rst_n clears the group state and sets groups_per_line to 16
`default_nettype none

module base64_stream_encoder
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    b64e_in_if.sink         in_chan,
    b64e_out_if.source      out_chan,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_data
);

    logic [5:0] gpl_reg;
    logic       take;
    burst_t     burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpl_reg <= GPL_RESET;
        end
        else if (cfg_we)
        begin
            gpl_reg <= cfg_data;
        end
    end

    b64e_encode u_encode (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_chan         (in_chan),
        .groups_per_line (gpl_reg),
        .take            (take),
        .burst           (burst)
    );

    b64e_serialize u_serialize (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst    (burst),
        .take     (take),
        .out_chan (out_chan)
    );

endmodule

`default_nettype wire
